// ----- hw/rtl/falc_pkg.sv -----
// ============================================================================
// falc_pkg: shared types and constants for the fully associative LRU cache
// Sizes of the way store, key width, and the structs passed between the
// controller and the row of way cells.
// ============================================================================
package falc_pkg;

    localparam int WAYS      = 16;
    localparam int KEY_BITS  = 32;
    localparam int LKEY_W    = 32;
    localparam int CFG_W     = 5;
    localparam int OUT_WAY_W = 4;
    localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int CNT_W     = $clog2(WAYS + 1);
    localparam int N_W       = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    typedef logic [KEY_BITS-1:0] key_t;
    typedef logic [WAY_W-1:0]    way_t;
    typedef logic [WAY_W-1:0]    rank_t;
    typedef logic [CNT_W-1:0]    count_t;

    localparam rank_t RANK_MAX = rank_t'(WAYS - 1);

    // Per-cell qualifiers derived from the fill count and the ways in use.
    typedef struct packed {
        logic in_use;
        logic search;
    } cell_en_t;

    // Search state that travels down the row, one cell per cycle.
    typedef struct packed {
        logic  found;
        way_t  hit_way;
        rank_t hit_rank;
        way_t  vic_way;
        rank_t vic_rank;
    } scan_t;

    // Broadcast update applied by every cell in the commit cycle.
    typedef struct packed {
        logic  valid;
        way_t  way;
        logic  write_key;
        logic  age_all;
        rank_t old_rank;
    } cell_upd_t;

    localparam scan_t SCAN_INIT = '{
        found:    1'b0,
        hit_way:  '0,
        hit_rank: '0,
        vic_way:  '0,
        vic_rank: '0
    };

endpackage

// ----- hw/rtl/falc_cell.sv -----
// ============================================================================
// falc_cell: one way of the fully associative LRU cache
// Holds one key and its recency rank, folds itself into the search state
// handed along the row, and applies the broadcast recency update.
// ============================================================================
module falc_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  falc_pkg::way_t       index,
    input  falc_pkg::cell_en_t   en,
    input  falc_pkg::key_t       key,
    input  falc_pkg::cell_upd_t  upd,
    input  falc_pkg::scan_t      carry_in,
    output falc_pkg::scan_t      carry_out
);
    import falc_pkg::*;

    key_t  key_reg;
    key_t  key_next;
    rank_t rank_reg;
    rank_t rank_next;
    scan_t carry_reg;
    scan_t carry_next;
    logic  is_target;

    assign is_target = upd.valid && (upd.way == index);

    always_comb
    begin
        key_next  = key_reg;
        rank_next = rank_reg;
        if (is_target)
        begin
            rank_next = '0;
            if (upd.write_key)
            begin
                key_next = key;
            end
        end
        else if (upd.valid && en.search && (upd.age_all || (rank_reg < upd.old_rank))
                 && (rank_reg != RANK_MAX))
        begin
            rank_next = rank_reg + rank_t'(1);
        end
    end

    // Lowest matching way wins; the victim is the lowest way of largest rank.
    always_comb
    begin
        carry_next = carry_in;
        if (en.search && (key_reg == key) && !carry_in.found)
        begin
            carry_next.found    = 1'b1;
            carry_next.hit_way  = index;
            carry_next.hit_rank = rank_reg;
        end
        if (en.in_use && (rank_reg > carry_in.vic_rank))
        begin
            carry_next.vic_way  = index;
            carry_next.vic_rank = rank_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_reg <= '0;
        end
        else
        begin
            rank_reg <= rank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        carry_reg <= carry_next;
    end

    assign carry_out = carry_reg;

endmodule

// ----- hw/rtl/fully_associative_lru_cache_unit.sv -----
// ============================================================================
// fully_associative_lru_cache_unit: fully associative LRU key cache
// Looks up one key per request in a row of way cells and reports hit, way
// and eviction, keeping least-recently-used order with per-way ranks.
// ============================================================================
// Each request carries one key. The key is held in a register and broadcast
// to a row of WAYS identical cells, each owning one way's key and recency
// rank (0 is most recent). A search record walks down the row one cell per
// cycle, picking up the lowest matching valid way and the lowest way with the
// largest rank among the ways in use. After the walk the commit state
// broadcasts the outcome: on a hit the way becomes most recent and younger
// ways age; on a miss the key fills the next empty way while the store is not
// full, otherwise it replaces the LRU way. Empty ways never match. From
// acceptance until the next request can be taken, a request passes through
// the accept in the idle state, the scan state while the search record
// crosses the cell row, and the commit state. The walk always covers all
// WAYS cells, whatever the number of ways in use. The commit waits while a
// previous response is still stalled on the output register. The request
// input stays stalled from acceptance until the commit, so requests are
// handled strictly one at a time. The ways_in_use register (reset 16; 0
// reads as 1, values above WAYS read as WAYS) is written through the cfg
// port, which is always ready, and must only be changed while no request
// is in flight.
// ============================================================================
module fully_associative_lru_cache_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [falc_pkg::CFG_W-1:0]       cfg_data,
    input  logic                             req_valid,
    output logic                             req_stall,
    input  logic [falc_pkg::LKEY_W-1:0]      lookup_key,
    output logic                             rsp_valid,
    input  logic                             rsp_stall,
    output logic                             hit,
    output logic [falc_pkg::OUT_WAY_W-1:0]   way_used,
    output logic                             replaced
);
    import falc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } state_t;

    state_t                 state_reg;
    state_t                 state_next;
    logic [CFG_W-1:0]       ways_cfg_reg;
    logic [CFG_W-1:0]       ways_cfg_next;
    count_t                 fill_count_reg;
    count_t                 fill_count_next;
    key_t                   key_reg;
    key_t                   key_next;
    way_t                   scan_cnt_reg;
    way_t                   scan_cnt_next;
    logic                   rsp_valid_reg;
    logic                   rsp_valid_next;
    logic                   hit_reg;
    logic                   hit_next;
    logic [OUT_WAY_W-1:0]   way_used_reg;
    logic [OUT_WAY_W-1:0]   way_used_next;
    logic                   replaced_reg;
    logic                   replaced_next;

    logic [N_W-1:0]         n_wide;
    count_t                 n_active;
    logic                   out_free;
    logic                   commit;
    logic                   miss_fill;
    scan_t                  scan_final;
    cell_upd_t              upd;
    cell_en_t               cell_en [WAYS];
    scan_t                  chain   [WAYS];

    // Clamp the configured way count to the range 1..WAYS.
    always_comb
    begin
        n_wide = N_W'(ways_cfg_reg);
        if (n_wide == '0)
        begin
            n_active = count_t'(1);
        end
        else if (n_wide > N_W'(WAYS))
        begin
            n_active = count_t'(WAYS);
        end
        else
        begin
            n_active = count_t'(n_wide);
        end
    end

    assign out_free   = !rsp_valid_reg || !rsp_stall;
    assign commit     = (state_reg == ST_COMMIT) && out_free;
    assign scan_final = chain[WAYS-1];
    assign miss_fill  = !scan_final.found && (fill_count_reg < n_active);

    // Outcome of the search, broadcast to every cell in the commit cycle.
    always_comb
    begin
        upd.valid     = commit;
        upd.write_key = !scan_final.found;
        upd.age_all   = !scan_final.found;
        upd.old_rank  = scan_final.hit_rank;
        if (scan_final.found)
        begin
            upd.way = scan_final.hit_way;
        end
        else if (miss_fill)
        begin
            upd.way = way_t'(fill_count_reg);
        end
        else
        begin
            upd.way = scan_final.vic_way;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < WAYS; gi++)
        begin : g_way
            scan_t carry_in;

            assign cell_en[gi].in_use = count_t'(gi) < n_active;
            assign cell_en[gi].search = (count_t'(gi) < n_active)
                                        && (count_t'(gi) < fill_count_reg);

            if (gi == 0)
            begin : g_head
                assign carry_in = SCAN_INIT;
            end
            else
            begin : g_link
                assign carry_in = chain[gi-1];
            end

            falc_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .index     (way_t'(gi)),
                .en        (cell_en[gi]),
                .key       (key_reg),
                .upd       (upd),
                .carry_in  (carry_in),
                .carry_out (chain[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next      = state_reg;
        ways_cfg_next   = ways_cfg_reg;
        fill_count_next = fill_count_reg;
        key_next        = key_reg;
        scan_cnt_next   = scan_cnt_reg;
        rsp_valid_next  = rsp_valid_reg;
        hit_next        = hit_reg;
        way_used_next   = way_used_reg;
        replaced_next   = replaced_reg;

        if (cfg_valid)
        begin
            ways_cfg_next = cfg_data;
        end

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    key_next      = KEY_BITS'(lookup_key);
                    scan_cnt_next = '0;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                scan_cnt_next = scan_cnt_reg + way_t'(1);
                if (scan_cnt_reg == way_t'(WAYS - 1))
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    hit_next       = scan_final.found;
                    way_used_next  = OUT_WAY_W'(upd.way);
                    replaced_next  = !scan_final.found && !miss_fill;
                    if (miss_fill)
                    begin
                        fill_count_next = fill_count_reg + count_t'(1);
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            ways_cfg_reg   <= CFG_W'(16);
            fill_count_reg <= '0;
            key_reg        <= '0;
            scan_cnt_reg   <= '0;
            rsp_valid_reg  <= 1'b0;
            hit_reg        <= 1'b0;
            way_used_reg   <= '0;
            replaced_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ways_cfg_reg   <= ways_cfg_next;
            fill_count_reg <= fill_count_next;
            key_reg        <= key_next;
            scan_cnt_reg   <= scan_cnt_next;
            rsp_valid_reg  <= rsp_valid_next;
            hit_reg        <= hit_next;
            way_used_reg   <= way_used_next;
            replaced_reg   <= replaced_next;
        end
    end

    assign cfg_ready = 1'b1;
    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign hit       = hit_reg;
    assign way_used  = way_used_reg;
    assign replaced  = replaced_reg;

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// ============================================================================
// tb_top: self-checking testbench for fully_associative_lru_cache_unit
// Drives key lookup requests and ways_in_use writes, predicts hit, way and
// eviction for every accepted request, and compares each response in order.
// ============================================================================
module tb_top;

    import falc_pkg::*;

    // Expected outcome of one lookup, in the order responses must come back.
    typedef struct packed {
        logic hit;
        way_t way;
        logic evicted;
    } lookup_result_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_W-1:0]     cfg_data;
    logic                 req_valid;
    logic                 req_stall;
    logic [LKEY_W-1:0]    lookup_key;
    logic                 rsp_valid;
    logic                 rsp_stall;
    logic                 hit;
    logic [OUT_WAY_W-1:0] way_used;
    logic                 replaced;

    // Shadow copy of the cache contents, kept in step with accepted requests.
    key_t             cached_key [WAYS];
    rank_t            age_rank [WAYS];
    count_t           fill_ct;
    logic [CFG_W-1:0] ways_reg;

    lookup_result_t pending_results [$];
    int             errors;
    bit             idle_on;
    int             rsp_hold;

    fully_associative_lru_cache_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .lookup_key (lookup_key),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .hit        (hit),
        .way_used   (way_used),
        .replaced   (replaced)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Generous overall limit; a hung handshake or a lost response ends here.
    initial
    begin
        #5_000_000;
        $display("FAIL fully_associative_lru_cache_unit");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Predictor. Applies one lookup to the shadow state and returns what the
    // block must report. Ranks: 0 is most recent, larger is older.
    // ------------------------------------------------------------------------
    function automatic lookup_result_t predict_lookup(input key_t key);
        lookup_result_t res;
        int   n;
        int   lim;
        int   w;
        int   i;
        int   prior;
        rank_t oldest;
        logic found;

        // A setting of zero behaves as one way, anything past WAYS as WAYS.
        if (ways_reg == 0)
            n = 1;
        else if (ways_reg > WAYS)
            n = WAYS;
        else
            n = ways_reg;
        lim = (fill_ct < n) ? fill_ct : n;

        // Only filled ways inside the active range are searched; scanning
        // downward leaves the lowest matching way as the winner.
        found = 1'b0;
        w = 0;
        for (i = lim - 1; i >= 0; i--)
        begin
            if (cached_key[i] == key)
            begin
                found = 1'b1;
                w = i;
            end
        end

        res.evicted = 1'b0;
        if (found)
        begin
            prior = age_rank[w];
        end
        else if (fill_ct < n)
        begin
            w = fill_ct;
            cached_key[w] = key;
            fill_ct++;
            prior = WAYS;
        end
        else
        begin
            // Victim is the lowest way holding the largest rank.
            oldest = '0;
            w = 0;
            for (i = 0; i < n; i++)
            begin
                if (age_rank[i] > oldest)
                begin
                    oldest = age_rank[i];
                    w = i;
                end
            end
            cached_key[w] = key;
            res.evicted = 1'b1;
            prior = WAYS;
        end

        // Ways younger than the touched one age by one, saturating at the top.
        for (i = 0; i < n && i < fill_ct; i++)
        begin
            if (i != w && age_rank[i] < prior && age_rank[i] < WAYS - 1)
                age_rank[i]++;
        end
        age_rank[w] = '0;

        res.hit = found;
        res.way = way_t'(w);
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Monitor and checker. Everything is sampled at the rising edge, before
    // the block's registers update. A response is checked before a request
    // seen at the same edge is predicted, since no response can belong to a
    // request accepted at that very edge.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        lookup_result_t exp_res;
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("response with no request outstanding: hit %0d way %0d replaced %0d",
                           hit, way_used, replaced);
                    errors++;
                end
                else
                begin
                    exp_res = pending_results.pop_front();
                    if (hit !== exp_res.hit)
                    begin
                        $error("hit: expected %0d, actual %0d", exp_res.hit, hit);
                        errors++;
                    end
                    if (way_used !== exp_res.way)
                    begin
                        $error("way_used: expected %0d, actual %0d", exp_res.way, way_used);
                        errors++;
                    end
                    if (replaced !== exp_res.evicted)
                    begin
                        $error("replaced: expected %0d, actual %0d",
                               exp_res.evicted, replaced);
                        errors++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                ways_reg = cfg_data;
            if (req_valid && !req_stall)
                pending_results.push_back(predict_lookup(lookup_key));
        end
    end

    // ------------------------------------------------------------------------
    // Response side. For every response it draws a number of stall cycles,
    // then drops stall until one response is taken. A pending hold-off from
    // the backpressure test replaces the draw once.
    // ------------------------------------------------------------------------
    initial
    begin : rsp_side
        int n;
        rsp_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            n = idle_on ? $urandom_range(0, 19) : 0;
            if (rsp_hold > 0)
            begin
                n = rsp_hold;
                rsp_hold = 0;
            end
            repeat (n)
            begin
                @(negedge clk);
                rsp_stall <= 1'b1;
            end
            @(negedge clk);
            rsp_stall <= 1'b0;
            do @(posedge clk); while (!rsp_valid);
        end
    end

    // Offers one lookup request after a random gap and holds it until taken.
    // Valid is lowered only when a gap follows, so it never toggles twice in
    // one time step.
    task automatic send_lookup(input key_t key);
        int gap;
        gap = idle_on ? $urandom_range(0, 19) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid  <= 1'b1;
        lookup_key <= key;
        do @(posedge clk); while (req_stall);
    endtask

    // Stops offering requests and waits until every response is back, plus
    // one full lookup time so that the block is truly idle.
    task automatic drain();
        @(negedge clk);
        req_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (WAYS + 4) @(posedge clk);
    endtask

    // Writes ways_in_use; only ever called right after drain().
    task automatic set_ways(input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // After reset every way is empty, so even a key of zero must miss; the
    // default of 16 ways in use is exercised before any write.
    task automatic test_reset_empty();
        send_lookup(32'h0000_0000);
        send_lookup(32'h0000_0000);
        send_lookup(32'hFFFF_FFFF);
        drain();
    endtask

    // Shrinking the active range hides a filled way; a miss then places the
    // same key a second time below it, and widening again makes both match.
    task automatic test_shrink_duplicate();
        send_lookup(32'h1234_5678);
        drain();
        set_ways(5'd2);
        send_lookup(32'h1234_5678);
        drain();
        set_ways(5'd4);
        send_lookup(32'h1234_5678);
        drain();
    endtask

    // Fill the remaining ways of a small set, then force evictions with a
    // mix of hits that reorder recency.
    task automatic test_lru_replace();
        send_lookup(32'hAAAA_AAAA);
        send_lookup(32'h5555_5555);
        send_lookup(32'hFFFF_FFFF);
        send_lookup(32'h8000_0001);
        send_lookup(32'hAAAA_AAAA);
        send_lookup(32'h7FFF_FFFE);
        drain();
    endtask

    // Out-of-range settings: zero acts as one way, 31 and 17 as all ways.
    task automatic test_ways_extremes();
        set_ways(5'd0);
        send_lookup(32'h0F0F_0F0F);
        send_lookup(32'h0F0F_0F0F);
        send_lookup(32'hF0F0_F0F0);
        drain();
        set_ways(5'd31);
        send_lookup(32'h0F0F_0F0F);
        send_lookup(32'h0000_0001);
        drain();
        set_ways(5'd17);
        send_lookup(32'hF0F0_F0F0);
        drain();
    endtask

    // One burst of lookups with locality: most keys come from a pool of 2 to
    // 2 * WAYS + 2 keys, so hits, fills and evictions all occur.
    task automatic run_lookup_burst(input int count);
        key_t pool [$];
        key_t key;
        int   pool_size;
        int   i;
        pool_size = $urandom_range(2, 2 * WAYS + 2);
        for (i = 0; i < pool_size; i++)
        begin
            case ($urandom_range(0, 9))
                0:       pool.push_back(32'h0000_0000);
                1:       pool.push_back(32'hFFFF_FFFF);
                default: pool.push_back($urandom);
            endcase
        end
        for (i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 99) < 85)
                key = pool[$urandom_range(0, pool.size() - 1)];
            else
                key = $urandom;
            send_lookup(key);
        end
    endtask

    // The response side holds off for a long stretch while requests keep
    // coming, so the output register fills, the next lookup waits in its commit
    // and the block stalls its request input.
    task automatic test_backpressure();
        set_ways(5'd8);
        idle_on = 1'b0;
        rsp_hold = 300;
        run_lookup_burst(12);
        drain();
        idle_on = 1'b1;
    endtask

    // Random traffic over several settings, with some phases free of gaps.
    task automatic test_random_traffic();
        logic [CFG_W-1:0] settings [7] = '{5'd1, 5'd16, 5'd2, 5'd0, 5'd31, 5'd17, 5'd8};
        int phase;
        for (phase = 0; phase < 12; phase++)
        begin
            if (phase < 7)
                set_ways(settings[phase]);
            else
                set_ways(CFG_W'($urandom_range(1, WAYS)));
            idle_on = (phase % 3 != 2);
            run_lookup_burst(36);
            drain();
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        req_valid  = 1'b0;
        lookup_key = '0;
        errors     = 0;
        idle_on    = 1'b1;
        rsp_hold   = 0;
        // Shadow state matches the block after reset.
        fill_ct    = '0;
        ways_reg   = CFG_W'(WAYS);
        for (int i = 0; i < WAYS; i++)
        begin
            cached_key[i] = '0;
            age_rank[i]   = '0;
        end
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_empty();
        test_shrink_duplicate();
        set_ways(5'd4);
        test_lru_replace();
        test_ways_extremes();
        test_backpressure();
        test_random_traffic();

        drain();
        if (errors == 0)
            $display("PASS fully_associative_lru_cache_unit");
        else
            $display("FAIL fully_associative_lru_cache_unit");
        $finish;
    end

endmodule
